// ===== hdl/plo_pkg.sv =====
package plo_pkg;

   // Fixed field widths
   localparam int DEPTH_WIDTH = 20;

   // Register port geometry: one 32-bit register slot every 4 bytes
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_INDEX_LSB   = 2;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - CSR_INDEX_LSB;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEPTH_THRESHOLD = '0;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Per-item control bits handed from front to back
   typedef struct packed {
      logic leg_valid;   // a previous position existed
      logic deep;        // depth strictly above threshold
   } leg_ctrl_type;

   localparam int LEG_CTRL_WIDTH = $bits(leg_ctrl_type);

endpackage

// ===== hdl/plo_ifs.sv =====
// Input channel: one position sample per item
interface plo_req_if #(
   parameter int COORD_WIDTH = 24
) ();
   logic                                valid;
   logic                                ready;
   logic signed [COORD_WIDTH-1:0]       pos_x;
   logic signed [COORD_WIDTH-1:0]       pos_y;
   logic signed [plo_pkg::DEPTH_WIDTH-1:0] depth;

   modport source (output valid, output pos_x, output pos_y, output depth, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input depth, output ready);
endinterface

// Result channel: leg and running totals per item
interface plo_rsp_if #(
   parameter int LEG_WIDTH = 25,
   parameter int ACC_WIDTH = 48
) ();
   logic                 valid;
   logic                 ready;
   logic                 leg_valid;
   logic [LEG_WIDTH-1:0] leg_length;
   logic [ACC_WIDTH-1:0] total_length;
   logic [ACC_WIDTH-1:0] depth_length;

   modport source (output valid, output leg_valid, output leg_length,
                   output total_length, output depth_length, input ready);
   modport sink   (input valid, input leg_valid, input leg_length,
                   input total_length, input depth_length, output ready);
endinterface

// ===== hdl/plo_front.sv =====
module plo_front #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   plo_req_if.sink                                req,
   input  logic signed [plo_pkg::DEPTH_WIDTH-1:0] threshold,
   input  logic                                   q_full,
   output logic                                   q_push,
   output plo_pkg::leg_ctrl_type                  push_ctrl,
   output logic [COORD_WIDTH-1:0]                 push_dx,
   output logic [COORD_WIDTH-1:0]                 push_dy
);

   logic                          have_prev_ff, have_prev_in;
   logic [COORD_WIDTH-1:0]        prev_x_ff, prev_x_in;
   logic [COORD_WIDTH-1:0]        prev_y_ff, prev_y_in;
   logic [COORD_WIDTH:0]          diff_x, diff_y;
   logic [COORD_WIDTH:0]          mag_x, mag_y;
   logic                          accept;

   // Take an item whenever the queue has room
   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;
   assign q_push    = accept;

   // Signed differences, one bit wider so they cannot wrap
   assign diff_x = {req.pos_x[COORD_WIDTH-1], req.pos_x} - {prev_x_ff[COORD_WIDTH-1], prev_x_ff};
   assign diff_y = {req.pos_y[COORD_WIDTH-1], req.pos_y} - {prev_y_ff[COORD_WIDTH-1], prev_y_ff};

   // Magnitudes fit in COORD_WIDTH bits
   assign mag_x = diff_x[COORD_WIDTH] ? (~diff_x + 1'b1) : diff_x;
   assign mag_y = diff_y[COORD_WIDTH] ? (~diff_y + 1'b1) : diff_y;

   assign push_dx             = mag_x[COORD_WIDTH-1:0];
   assign push_dy             = mag_y[COORD_WIDTH-1:0];
   assign push_ctrl.leg_valid = have_prev_ff;
   assign push_ctrl.deep      = $signed(req.depth) > threshold;

   // Stored position
   always_comb begin
      have_prev_in = have_prev_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      if (accept) begin
         have_prev_in = 1'b1;
         prev_x_in    = req.pos_x;
         prev_y_in    = req.pos_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
      end else begin
         have_prev_ff <= have_prev_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
      end
   end

endmodule

// ===== hdl/plo_fifo.sv =====
module plo_fifo #(
   parameter int WIDTH = 50
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_WIDTH = (plo_pkg::QUEUE_DEPTH > 1) ? $clog2(plo_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(plo_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(plo_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] DEPTH_CNT = CNT_WIDTH'(plo_pkg::QUEUE_DEPTH);

   logic [WIDTH-1:0]     entry_ff [plo_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/plo_sqrt.sv =====
module plo_sqrt #(
   parameter int ROOT_WIDTH = 25
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [2*ROOT_WIDTH-1:0] radicand,
   output logic                    busy,
   output logic [ROOT_WIDTH-1:0]   root
);

   localparam int CNT_WIDTH = $clog2(ROOT_WIDTH);
   localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(ROOT_WIDTH - 1);

   logic [2*ROOT_WIDTH-1:0] rad_ff, rad_in;
   logic [ROOT_WIDTH:0]     rem_ff, rem_in;
   logic [ROOT_WIDTH-1:0]   root_ff, root_in;
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic [ROOT_WIDTH+1:0]   rem_sh, trial, rem_sub;
   logic                    fits;

   // One root bit per cycle: bring down two radicand bits, try 4*root+1
   assign rem_sh  = {rem_ff[ROOT_WIDTH-1:0], rad_ff[2*ROOT_WIDTH-1 -: 2]};
   assign trial   = {root_ff, 2'b01};
   assign fits    = (rem_sh >= trial);
   assign rem_sub = rem_sh - trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = LAST_STEP;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[2*ROOT_WIDTH-3:0], 2'b00};
         rem_in  = fits ? rem_sub[ROOT_WIDTH:0] : rem_sh[ROOT_WIDTH:0];
         root_in = {root_ff[ROOT_WIDTH-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ===== hdl/plo_back.sv =====
module plo_back #(
   parameter int COORD_WIDTH = 24,
   parameter int ACC_WIDTH   = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   output logic                   q_pop,
   input  plo_pkg::leg_ctrl_type  pop_ctrl,
   input  logic [COORD_WIDTH-1:0] pop_dx,
   input  logic [COORD_WIDTH-1:0] pop_dy,
   plo_rsp_if.source              rsp
);

   localparam int LEG_WIDTH = COORD_WIDTH + 1;
   localparam int SQ_WIDTH  = 2 * COORD_WIDTH;
   localparam int RAD_WIDTH = 2 * LEG_WIDTH;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_ACC  = 3'd4;

   logic [2:0]             state_ff, state_in;
   plo_pkg::leg_ctrl_type  ctrl_ff, ctrl_in;
   logic [COORD_WIDTH-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_WIDTH-1:0]    sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   logic [ACC_WIDTH-1:0]   total_ff, total_in, depth_acc_ff, depth_acc_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   out_leg_valid_ff, out_leg_valid_in;
   logic [LEG_WIDTH-1:0]   out_leg_ff, out_leg_in;
   logic                   sqrt_start, sqrt_busy;
   logic [LEG_WIDTH-1:0]   sqrt_root, leg;
   logic [RAD_WIDTH-1:0]   radicand;
   logic [ACC_WIDTH:0]     total_sum, depth_sum;
   logic                   out_free;

   plo_sqrt #(.ROOT_WIDTH(LEG_WIDTH)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .busy     (sqrt_busy),
      .root     (sqrt_root)
   );

   // Squares, registered before the add; operands widened so the full product is kept
   assign sq_x_in = SQ_WIDTH'(dx_ff) * SQ_WIDTH'(dx_ff);
   assign sq_y_in = SQ_WIDTH'(dy_ff) * SQ_WIDTH'(dy_ff);

   assign radicand   = RAD_WIDTH'(sq_x_ff) + RAD_WIDTH'(sq_y_ff);
   assign sqrt_start = (state_ff == ST_SUM);

   // Saturating accumulate; first sample adds nothing
   assign leg       = ctrl_ff.leg_valid ? sqrt_root : '0;
   assign total_sum = {1'b0, total_ff} + (ACC_WIDTH+1)'(leg);
   assign depth_sum = {1'b0, depth_acc_ff} + (ACC_WIDTH+1)'(leg);

   assign out_free = !out_valid_ff || rsp.ready;
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      ctrl_in          = ctrl_ff;
      dx_in            = dx_ff;
      dy_in            = dy_ff;
      total_in         = total_ff;
      depth_acc_in     = depth_acc_ff;
      out_valid_in     = out_valid_ff && !rsp.ready;
      out_leg_valid_in = out_leg_valid_ff;
      out_leg_in       = out_leg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               ctrl_in  = pop_ctrl;
               dx_in    = pop_dx;
               dy_in    = pop_dy;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (!sqrt_busy) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (out_free) begin
               total_in = total_sum[ACC_WIDTH] ? '1 : total_sum[ACC_WIDTH-1:0];
               if (ctrl_ff.deep) begin
                  depth_acc_in = depth_sum[ACC_WIDTH] ? '1 : depth_sum[ACC_WIDTH-1:0];
               end
               out_valid_in     = 1'b1;
               out_leg_valid_in = ctrl_ff.leg_valid;
               out_leg_in       = leg;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         depth_acc_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         depth_acc_ff <= depth_acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff          <= ctrl_in;
      dx_ff            <= dx_in;
      dy_ff            <= dy_in;
      sq_x_ff          <= sq_x_in;
      sq_y_ff          <= sq_y_in;
      out_leg_valid_ff <= out_leg_valid_in;
      out_leg_ff       <= out_leg_in;
   end

   // Result register; accumulators hold the reported totals
   assign rsp.valid        = out_valid_ff;
   assign rsp.leg_valid    = out_leg_valid_ff;
   assign rsp.leg_length   = out_leg_ff;
   assign rsp.total_length = total_ff;
   assign rsp.depth_length = depth_acc_ff;

endmodule

// ===== hdl/path_length_odometer_top.sv =====
// Channel    Direction  Handshake     Payload
// req_chan   in         valid/ready   pos_x, pos_y, depth
// rsp_chan   out        valid/ready   leg_valid, leg_length, total_length, depth_length
// csr        in         APB read/write depth_threshold at byte address 0
//
// The back end pops an item in its idle state, then works through it in turn: multiply,
// sum, bit-serial square root, accumulate. It pops the next item only once it is back in
// idle, so it does not take a new item before it is through with the last one.
// Reset is synchronous; it clears the stored position, both totals and the threshold.
// A two-entry queue lets the front keep taking items while the back end works; the
// accumulate step waits while the result register still holds an unaccepted item.
module path_length_odometer_top #(
   parameter int COORD_WIDTH = 24,
   parameter int ACC_WIDTH   = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   plo_req_if.sink                              req_chan,
   plo_rsp_if.source                            rsp_chan,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [plo_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [plo_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [plo_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready
);

   localparam int DW       = plo_pkg::DEPTH_WIDTH;
   localparam int Q_WIDTH  = plo_pkg::LEG_CTRL_WIDTH + 2 * COORD_WIDTH;

   logic signed [DW-1:0]                   threshold_ff, threshold_in;
   logic [plo_pkg::CSR_INDEX_WIDTH-1:0]    csr_index;
   logic                                   csr_hit;
   logic                                   q_full, q_empty, q_push, q_pop;
   plo_pkg::leg_ctrl_type                  push_ctrl, pop_ctrl;
   logic [COORD_WIDTH-1:0]                 push_dx, push_dy, pop_dx, pop_dy;
   logic [Q_WIDTH-1:0]                     push_data, pop_data;

   // Register port
   assign pready    = 1'b1;
   assign csr_index = paddr[plo_pkg::CSR_ADDR_WIDTH-1:plo_pkg::CSR_INDEX_LSB];
   assign csr_hit   = (csr_index == plo_pkg::REG_DEPTH_THRESHOLD);
   assign prdata    = csr_hit ? {{(plo_pkg::CSR_DATA_WIDTH-DW){threshold_ff[DW-1]}}, threshold_ff}
                              : '0;

   always_comb begin
      threshold_in = threshold_ff;
      if (psel && penable && pwrite && csr_hit) begin
         threshold_in = pwdata[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   plo_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .threshold (threshold_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .push_ctrl (push_ctrl),
      .push_dx   (push_dx),
      .push_dy   (push_dy)
   );

   assign push_data = {push_ctrl, push_dx, push_dy};

   plo_fifo #(.WIDTH(Q_WIDTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   assign pop_ctrl = pop_data[Q_WIDTH-1 -: plo_pkg::LEG_CTRL_WIDTH];
   assign pop_dx   = pop_data[2*COORD_WIDTH-1:COORD_WIDTH];
   assign pop_dy   = pop_data[COORD_WIDTH-1:0];

   plo_back #(.COORD_WIDTH(COORD_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .pop_ctrl (pop_ctrl),
      .pop_dx   (pop_dx),
      .pop_dy   (pop_dy),
      .rsp      (rsp_chan)
   );

`ifndef SYNTHESIS
   // Depth total can never pass the overall total
   a_depth_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.depth_length <= rsp_chan.total_length))
      else $error("depth total exceeds overall total");

   // Only the first item after reset has no leg, and then nothing is accumulated
   a_first_item_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.leg_valid) |->
         (rsp_chan.leg_length == '0 && rsp_chan.total_length == '0 &&
          rsp_chan.depth_length == '0))
      else $error("first item reports nonzero leg or totals");

   // No result right out of reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid right after reset");

   // Queue cannot be full and empty together
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue flags inconsistent");
`endif

endmodule

// ===== dv/path_length_odometer_checker.sv =====
// Watches the sample, result and register channels of the odometer, keeps its
// own running copy of position, totals and threshold, and compares each result
// item with the oldest predicted one.
module path_length_odometer_checker (
   input  logic                               clock,
   input  logic                               reset,
   plo_req_if                                 req_mon,
   plo_rsp_if                                 rsp_mon,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [plo_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [plo_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   input  logic [plo_pkg::CSR_DATA_WIDTH-1:0] prdata,
   input  logic                               pready,
   output int                                 mismatches,
   output int                                 pending,
   output int                                 compared
);

   localparam int COORD_W   = 24;
   localparam int LEG_W     = 25;
   localparam int ACC_W     = 48;
   localparam int DEPTH_W   = plo_pkg::DEPTH_WIDTH;
   localparam int DUE_SLOTS = 64;

   typedef struct packed {
      logic             leg_valid;
      logic [LEG_W-1:0] leg_length;
      logic [ACC_W-1:0] total_length;
      logic [ACC_W-1:0] depth_length;
   } leg_report_type;

   // Odometer state as this side sees it
   logic                      have_fix;
   logic signed [COORD_W-1:0] last_x;
   logic signed [COORD_W-1:0] last_y;
   logic [ACC_W-1:0]          total_acc;
   logic [ACC_W-1:0]          deep_acc;
   logic signed [DEPTH_W-1:0] threshold;

   // predicted results, oldest at due_head
   leg_report_type legs_due [DUE_SLOTS];
   int             due_head;
   int             due_tail;
   int             error_count;
   int             compare_count;

   logic [plo_pkg::CSR_INDEX_WIDTH-1:0] csr_index;

   assign csr_index = paddr[plo_pkg::CSR_ADDR_WIDTH-1:plo_pkg::CSR_INDEX_LSB];

   task automatic report_mismatch(input string what);
      $display("[%0t] odometer mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Floor square root, one root bit per pass, most significant first
   function automatic logic [LEG_W-1:0] floor_sqrt(input logic [63:0] n);
      logic [LEG_W-1:0] root;
      logic [LEG_W-1:0] trial;
      logic [63:0]      sqr;
      root = '0;
      for (int i = LEG_W - 1; i >= 0; i--) begin
         trial = root | (LEG_W'(1) << i);
         sqr   = 64'(trial) * 64'(trial);
         if (sqr <= n) root = trial;
      end
      return root;
   endfunction

   // Sum held at all ones once it would carry out
   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                input logic [LEG_W-1:0] leg);
      logic [ACC_W:0] sum;
      sum = {1'b0, acc} + (ACC_W + 1)'(leg);
      return sum[ACC_W] ? '1 : sum[ACC_W-1:0];
   endfunction

   // Advance the odometer by one sample and return what the block should report
   function automatic leg_report_type log_sample(input logic signed [COORD_W-1:0] x,
                                                 input logic signed [COORD_W-1:0] y,
                                                 input logic signed [DEPTH_W-1:0] d);
      longint         dx;
      longint         dy;
      logic [63:0]    sq;
      leg_report_type r;
      r = '0;
      if (have_fix) begin
         dx = longint'(x) - longint'(last_x);
         dy = longint'(y) - longint'(last_y);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         sq = 64'(dx * dx + dy * dy);
         r.leg_valid  = 1'b1;
         r.leg_length = floor_sqrt(sq);
         total_acc    = sat_add(total_acc, r.leg_length);
         // strict compare: depth equal to the threshold is not at depth
         if (d > threshold) deep_acc = sat_add(deep_acc, r.leg_length);
      end
      last_x         = x;
      last_y         = y;
      have_fix       = 1'b1;
      r.total_length = total_acc;
      r.depth_length = deep_acc;
      return r;
   endfunction

   always @(posedge clock) begin
      leg_report_type want;
      if (reset) begin
         have_fix  = 1'b0;
         last_x    = '0;
         last_y    = '0;
         total_acc = '0;
         deep_acc  = '0;
         threshold = '0;
         due_head  = 0;
         due_tail  = 0;
      end else begin
         // register port: track writes, check reads of the mapped register
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (csr_index == plo_pkg::REG_DEPTH_THRESHOLD)
                  threshold = pwdata[DEPTH_W-1:0];
            end else if (csr_index == plo_pkg::REG_DEPTH_THRESHOLD) begin
               if (prdata[DEPTH_W-1:0] !== threshold)
                  report_mismatch($sformatf("threshold read %0h, want %0h",
                                            prdata[DEPTH_W-1:0], threshold));
            end
         end

         // result items against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_tail == due_head) begin
               report_mismatch("result item with no sample outstanding");
            end else begin
               want = legs_due[due_head % DUE_SLOTS];
               due_head++;
               compare_count++;
               if (rsp_mon.leg_valid !== want.leg_valid)
                  report_mismatch($sformatf("leg_valid %0b, want %0b",
                                            rsp_mon.leg_valid, want.leg_valid));
               if (rsp_mon.leg_length !== want.leg_length)
                  report_mismatch($sformatf("leg_length %0d, want %0d",
                                            rsp_mon.leg_length, want.leg_length));
               if (rsp_mon.total_length !== want.total_length)
                  report_mismatch($sformatf("total_length %0d, want %0d",
                                            rsp_mon.total_length, want.total_length));
               if (rsp_mon.depth_length !== want.depth_length)
                  report_mismatch($sformatf("depth_length %0d, want %0d",
                                            rsp_mon.depth_length, want.depth_length));
            end
         end

         // accepted sample items
         if (req_mon.valid && req_mon.ready) begin
            if (due_tail - due_head >= DUE_SLOTS)
               report_mismatch("more samples outstanding than the block can hold");
            legs_due[due_tail % DUE_SLOTS] =
               log_sample(req_mon.pos_x, req_mon.pos_y, req_mon.depth);
            due_tail++;
         end
      end
      mismatches <= error_count;
      pending    <= due_tail - due_head;
      compared   <= compare_count;
   end

endmodule

// ===== dv/path_length_odometer_top_test.sv =====
// Drives position samples and threshold writes into the odometer; the checker
// beside it does the prediction and comparison.
module path_length_odometer_top_test;

   localparam int COORD_W      = 24;
   localparam int DEPTH_W      = plo_pkg::DEPTH_WIDTH;
   localparam int ADDR_W       = plo_pkg::CSR_ADDR_WIDTH;
   localparam int DATA_W       = plo_pkg::CSR_DATA_WIDTH;
   localparam int RANDOM_ITEMS = 1930;
   localparam int PHASES       = 6;
   localparam int CALM_TAIL    = 250;
   localparam int DRAIN_CYCLES = 2 * (COORD_W + 6) + 10;

   localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [DEPTH_W-1:0] D_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
   localparam logic signed [DEPTH_W-1:0] D_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

   localparam logic [ADDR_W-1:0] ADDR_THRESHOLD =
      ADDR_W'(plo_pkg::REG_DEPTH_THRESHOLD) << plo_pkg::CSR_INDEX_LSB;
   localparam logic [ADDR_W-1:0] ADDR_UNMAPPED =
      ADDR_W'(plo_pkg::REG_DEPTH_THRESHOLD + 1) << plo_pkg::CSR_INDEX_LSB;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   int mismatches;
   int pending;
   int compared;

   // stimulus bookkeeping
   logic signed [COORD_W-1:0] cur_x;
   logic signed [COORD_W-1:0] cur_y;
   logic signed [DEPTH_W-1:0] thresh_now;
   int                        samples_sent;
   int                        settings_used;
   bit                        no_idle;
   bit                        src_calm;

   plo_req_if #(.COORD_WIDTH(COORD_W)) req_chan ();
   plo_rsp_if                          rsp_chan ();

   path_length_odometer_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   path_length_odometer_checker watcher (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .mismatches (mismatches),
      .pending    (pending),
      .compared   (compared)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // APB write: setup cycle, then access until pready
   task automatic csr_write(input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_read(input logic [ADDR_W-1:0] addr);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // upper data bits carry noise; only the low field should matter
   task automatic set_threshold(input logic signed [DEPTH_W-1:0] thr);
      logic [DATA_W-1:0] word;
      word              = $urandom();
      word[DEPTH_W-1:0] = thr;
      csr_write(ADDR_THRESHOLD, word);
      csr_read(ADDR_THRESHOLD);
      thresh_now = thr;
      settings_used++;
   endtask

   // drop valid and wait until every result has come back
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic send_sample(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic signed [DEPTH_W-1:0] d);
      int gap;
      gap = 0;
      if (!no_idle && !src_calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pos_x <= x;
      req_chan.pos_y <= y;
      req_chan.depth <= d;
      do @(posedge clock); while (!req_chan.ready);
      cur_x = x;
      cur_y = y;
      samples_sent++;
      if (samples_sent % 64 == 0) src_calm = ($urandom_range(0, 3) == 0);
   endtask

   function automatic logic signed [COORD_W-1:0] pick_corner(input int sel);
      case (sel)
         0:       return C_MAX;
         1:       return C_MIN;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   // mostly short hops around the current fix, with jumps, corners and stops
   task automatic random_sample();
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [DEPTH_W-1:0] d;
      int                        pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2, 3, 4: begin
            x = cur_x + COORD_W'($urandom_range(0, 64)) - COORD_W'(32);
            y = cur_y + COORD_W'($urandom_range(0, 64)) - COORD_W'(32);
         end
         5, 6: begin
            x = cur_x + COORD_W'($urandom_range(0, 8192)) - COORD_W'(4096);
            y = cur_y + COORD_W'($urandom_range(0, 8192)) - COORD_W'(4096);
         end
         7: begin
            x = COORD_W'($urandom());
            y = COORD_W'($urandom());
         end
         8: begin
            x = pick_corner($urandom_range(0, 3));
            y = pick_corner($urandom_range(0, 3));
         end
         default: begin
            x = cur_x;
            y = cur_y;
         end
      endcase
      pick = $urandom_range(0, 7);
      case (pick)
         0, 1, 2: d = thresh_now + DEPTH_W'(pick) - DEPTH_W'(1);
         3:       d = $urandom_range(0, 1) ? D_MAX : D_MIN;
         default: d = DEPTH_W'($urandom());
      endcase
      send_sample(x, y, d);
   endtask

   // result side back-pressure: bursts of stall, with calm stretches
   initial begin : sink_pacing
      int  hold;
      int  span;
      bit  calm;
      hold = 0;
      span = 0;
      calm = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (span == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            span = 200;
         end
         span--;
         if (hold > 0) begin
            hold--;
            rsp_chan.ready <= 1'b0;
         end else if (!no_idle && !calm && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(1, 18) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic signed [DEPTH_W-1:0] plan [PHASES];
      int                        per_phase;
      cur_x          = '0;
      cur_y          = '0;
      thresh_now     = '0;
      samples_sent   = 0;
      settings_used  = 0;
      no_idle        = 1'b0;
      src_calm       = 1'b0;
      reset          <= 1'b1;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      req_chan.valid <= 1'b0;
      req_chan.pos_x <= '0;
      req_chan.pos_y <= '0;
      req_chan.depth <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // threshold comes out of reset at zero
      csr_read(ADDR_THRESHOLD);

      // directed: first fix, strict depth compare, corners and sign bits
      send_sample('0, '0, '0);
      send_sample(COORD_W'(3), COORD_W'(4), DEPTH_W'(1));
      send_sample(COORD_W'(3), COORD_W'(4), '0);
      send_sample(-COORD_W'(3), -COORD_W'(4), '1);
      send_sample(C_MAX, C_MAX, D_MAX);
      send_sample(C_MIN, C_MIN, D_MAX);
      send_sample(C_MAX, C_MIN, D_MIN);
      send_sample(C_MIN, C_MAX, '0);
      send_sample('1, '1, DEPTH_W'(1));
      send_sample('0, '0, '1);
      send_sample(COORD_W'(1), '0, DEPTH_W'(1));
      send_sample(COORD_W'(1), COORD_W'(1), '0);
      send_sample('0, C_MIN, DEPTH_W'(1));
      send_sample(C_MAX, '0, D_MIN);
      send_sample('1, '0, D_MAX);

      // negative threshold: below, equal, above
      wait_idle();
      set_threshold('1);
      send_sample(COORD_W'(100), '0, -DEPTH_W'(2));
      send_sample(COORD_W'(100), COORD_W'(50), '1);
      send_sample('0, COORD_W'(50), '0);

      // unmapped register: write is dropped, threshold must read back unchanged
      wait_idle();
      csr_write(ADDR_UNMAPPED, $urandom());
      csr_read(ADDR_THRESHOLD);
      csr_read(ADDR_UNMAPPED);

      plan[0] = D_MIN;
      plan[1] = D_MAX;
      plan[2] = DEPTH_W'($urandom());
      plan[3] = '0;
      plan[4] = DEPTH_W'($urandom_range(0, 200)) - DEPTH_W'(100);
      plan[5] = DEPTH_W'($urandom());
      per_phase = RANDOM_ITEMS / PHASES;

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         set_threshold(plan[p]);
         for (int n = 0; n < per_phase; n++) begin
            if (p == PHASES - 1 && n >= per_phase - CALM_TAIL) no_idle = 1'b1;
            random_sample();
         end
      end

      // drain
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Drove %0d position samples under %0d threshold settings, %0d results compared.",
               samples_sent, settings_used, compared);
      $display("Covered first fix, zero and corner-to-corner legs, %s",
               "depth at and around each threshold.");
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Run did not finish in time, %0d results still outstanding.", pending);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
